>>> rtl/ifd_pkg.sv
// Shared types and constants for the impact-then-quiet fall detector.
package ifd_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int unsigned CFG_IW = 2;
	localparam int unsigned CFG_DW = 32;

	localparam logic [31:0] IMPACT_RESET = 32'd1677721600;
	localparam logic [31:0] QUIET_RESET  = 32'd386547057;
	localparam logic [15:0] SETTLE_RESET = 16'd2000;
	localparam logic [31:0] IMPACT_FLOOR = 32'd24159192;
	localparam logic [31:0] QUIET_FLOOR  = 32'd671089;
	localparam logic [15:0] SETTLE_FLOOR = 16'd100;

	typedef enum logic [CFG_IW-1:0] {
		CFG_IMPACT = 2'd0,
		CFG_QUIET  = 2'd1,
		CFG_SETTLE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_ARMED = 2'b10
	} det_state_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic        [31:0] time_ms;
		logic        [31:0] mag_sq;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> rtl/impact_quiet_fall_detector_top.sv
// Top level of the impact-then-quiet fall detector.
// Takes one motion sample per cycle when in_ready is high and returns one result per sample,
// in order. A sample passes two front stages (axis squares, then magnitude sum), a
// four-entry queue and the detector register stage; throughput is one sample per cycle
// when nothing stalls, as the back-end detector updates once per accepted sample. The
// user must write thresholds through the cfg port only while no sample is in flight; the
// block itself does not enforce this. A write below a threshold's floor is dropped.
module impact_quiet_fall_detector_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [ifd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ifd_pkg::CFG_DW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [15:0]         accel_x,
	input  logic signed [15:0]         accel_y,
	input  logic signed [15:0]         accel_z,
	input  logic signed [15:0]         rate_x,
	input  logic signed [15:0]         rate_y,
	input  logic signed [15:0]         rate_z,
	input  logic        [31:0]         sample_time_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       fall_now,
	output logic                       impact_armed,
	output logic                       event_valid,
	output logic signed [15:0]         event_accel_x,
	output logic signed [15:0]         event_accel_y,
	output logic signed [15:0]         event_accel_z,
	output logic signed [15:0]         event_rate_x,
	output logic signed [15:0]         event_rate_y,
	output logic signed [15:0]         event_rate_z,
	output logic        [31:0]         event_mag_sq,
	output logic        [31:0]         event_time_ms
);
	import ifd_pkg::*;

	fifo_stat_t q_stat;
	item_t      push_item;
	item_t      head_item;
	logic       q_push;
	logic       q_pop;

	ifd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.rate_x         (rate_x),
		.rate_y         (rate_y),
		.rate_z         (rate_z),
		.sample_time_ms (sample_time_ms),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_item         (push_item)
	);

	ifd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	ifd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_stat        (q_stat),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fall_now      (fall_now),
		.impact_armed  (impact_armed),
		.event_valid   (event_valid),
		.event_accel_x (event_accel_x),
		.event_accel_y (event_accel_y),
		.event_accel_z (event_accel_z),
		.event_rate_x  (event_rate_x),
		.event_rate_y  (event_rate_y),
		.event_rate_z  (event_rate_z),
		.event_mag_sq  (event_mag_sq),
		.event_time_ms (event_time_ms)
	);

endmodule

>>> rtl/ifd_front.sv
// Front end: accepts samples, squares the axes and sums the squared magnitude.
module ifd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    accel_x,
	input  logic signed [15:0]    accel_y,
	input  logic signed [15:0]    accel_z,
	input  logic signed [15:0]    rate_x,
	input  logic signed [15:0]    rate_y,
	input  logic signed [15:0]    rate_z,
	input  logic        [31:0]    sample_time_ms,
	input  ifd_pkg::fifo_stat_t   q_stat,
	output logic                  q_push,
	output ifd_pkg::item_t        q_item
);
	import ifd_pkg::*;

	logic               valid_s1;
	logic               valid_s2;
	item_t              sample_s1;
	item_t              item_s2;
	logic        [31:0] sq_x_s1;
	logic        [31:0] sq_y_s1;
	logic        [31:0] sq_z_s1;
	logic signed [31:0] prod_x;
	logic signed [31:0] prod_y;
	logic signed [31:0] prod_z;
	logic               load_s2;
	logic               load_s1;

	assign prod_x = accel_x * accel_x;
	assign prod_y = accel_y * accel_y;
	assign prod_z = accel_z * accel_z;

	assign q_push   = valid_s2 && !q_stat.full;
	assign q_item   = item_s2;
	assign load_s2  = !valid_s2 || q_push;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			sample_s1.accel_x <= accel_x;
			sample_s1.accel_y <= accel_y;
			sample_s1.accel_z <= accel_z;
			sample_s1.rate_x  <= rate_x;
			sample_s1.rate_y  <= rate_y;
			sample_s1.rate_z  <= rate_z;
			sample_s1.time_ms <= sample_time_ms;
			sample_s1.mag_sq  <= 32'd0;
			sq_x_s1           <= unsigned'(prod_x);
			sq_y_s1           <= unsigned'(prod_y);
			sq_z_s1           <= unsigned'(prod_z);
		end
		if (load_s2 && valid_s1) begin
			item_s2 <= {sample_s1[$bits(item_t)-1:32], sq_x_s1 + sq_y_s1 + sq_z_s1};
		end
	end

	ap_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	ap_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(sq_x_s1))
		else $error("stalled stage one lost its sample");

	ap_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty front refused a sample");

endmodule

>>> rtl/ifd_fifo.sv
// Short queue of samples with their squared magnitude between the front and back ends.
module ifd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ifd_pkg::item_t       push_item,
	input  logic                 pop,
	output ifd_pkg::item_t       head_item,
	output ifd_pkg::fifo_stat_t  stat
);
	import ifd_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_item  = mem_q[rd_ptr_q];

	function automatic logic [FIFO_AW-1:0] next_ptr(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	ap_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on transfer out");

	ap_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not rise on transfer in");

endmodule

>>> rtl/ifd_back.sv
// Back end: detector state, threshold registers and the latched result.
module ifd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [ifd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ifd_pkg::CFG_DW-1:0] cfg_data,
	input  ifd_pkg::fifo_stat_t        q_stat,
	input  ifd_pkg::item_t             q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       fall_now,
	output logic                       impact_armed,
	output logic                       event_valid,
	output logic signed [15:0]         event_accel_x,
	output logic signed [15:0]         event_accel_y,
	output logic signed [15:0]         event_accel_z,
	output logic signed [15:0]         event_rate_x,
	output logic signed [15:0]         event_rate_y,
	output logic signed [15:0]         event_rate_z,
	output logic        [31:0]         event_mag_sq,
	output logic        [31:0]         event_time_ms
);
	import ifd_pkg::*;

	logic [31:0] impact_level_q;
	logic [31:0] quiet_level_q;
	logic [15:0] settle_window_q;
	det_state_t  state_q;
	det_state_t  state_d;
	logic [31:0] impact_time_q;
	logic        out_valid_q;
	logic        fall_q;
	logic        have_event_q;
	item_t       event_q;
	logic [31:0] elapsed;
	logic        fall_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_level_q  <= IMPACT_RESET;
			quiet_level_q   <= QUIET_RESET;
			settle_window_q <= SETTLE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IMPACT: begin
					if (cfg_data >= IMPACT_FLOOR) impact_level_q <= cfg_data;
				end
				CFG_QUIET: begin
					if (cfg_data >= QUIET_FLOOR) quiet_level_q <= cfg_data;
				end
				CFG_SETTLE: begin
					if (cfg_data[15:0] >= SETTLE_FLOOR) settle_window_q <= cfg_data[15:0];
				end
				default: ;
			endcase
		end
	end

	assign q_pop   = !q_stat.empty && (!out_valid_q || out_ready);
	assign elapsed = q_item.time_ms - impact_time_q;

	always_comb begin
		state_d = state_q;
		fall_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_item.mag_sq >= impact_level_q) state_d = ST_ARMED;
			end
			ST_ARMED: begin
				priority if (elapsed > {16'd0, settle_window_q}) begin
					state_d = ST_IDLE;
				end else if (q_item.mag_sq <= quiet_level_q) begin
					state_d = ST_IDLE;
					fall_d  = 1'b1;
				end else begin
					state_d = ST_ARMED;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			impact_time_q <= '0;
			out_valid_q   <= 1'b0;
			fall_q        <= 1'b0;
			have_event_q  <= 1'b0;
			event_q       <= '0;
		end else begin
			out_valid_q <= q_pop || (out_valid_q && !out_ready);
			if (q_pop) begin
				state_q     <= state_d;
				fall_q      <= fall_d;
				if (state_q == ST_IDLE && state_d == ST_ARMED) impact_time_q <= q_item.time_ms;
				if (fall_d) begin
					have_event_q <= 1'b1;
					event_q      <= q_item;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign fall_now      = fall_q;
	assign impact_armed  = (state_q == ST_ARMED);
	assign event_valid   = have_event_q;
	assign event_accel_x = event_q.accel_x;
	assign event_accel_y = event_q.accel_y;
	assign event_accel_z = event_q.accel_z;
	assign event_rate_x  = event_q.rate_x;
	assign event_rate_y  = event_q.rate_y;
	assign event_rate_z  = event_q.rate_z;
	assign event_mag_sq  = event_q.mag_sq;
	assign event_time_ms = event_q.time_ms;

	ap_fall_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fall_q |-> have_event_q && state_q == ST_IDLE)
		else $error("fall reported without latched event or still armed");

	ap_fall_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fall_q |-> event_q.mag_sq <= quiet_level_q)
		else $error("latched fall sample above quiet level");

	ap_floors_kept: assert property (@(posedge clk) disable iff (!arst_n)
		impact_level_q >= IMPACT_FLOOR && quiet_level_q >= QUIET_FLOOR
		&& settle_window_q >= SETTLE_FLOOR)
		else $error("threshold register below its floor");

	ap_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(event_q) && $stable(fall_q))
		else $error("stalled result changed");

endmodule
